@@ rtl/delta_r_jet_matcher_top_defines.svh @@
// ----------------------------------------------------------------------------
// delta_r_jet_matcher_top_defines
// assertion macros shared by the jet matcher rtl
// ----------------------------------------------------------------------------
`ifndef DELTA_R_JET_MATCHER_TOP_DEFINES_SVH
`define DELTA_R_JET_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DRJM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drjm assertion failed");

// next-cycle implication, checked out of reset
`define DRJM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drjm assertion failed");

`endif

@@ rtl/drjm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drjm_pkg
// shared types and constants of the delta-r jet matcher
// ----------------------------------------------------------------------------
package drjm_pkg;

    localparam int MAX_RECO_JETS = 16;
    localparam int IDX_W = (MAX_RECO_JETS > 1) ? $clog2(MAX_RECO_JETS) : 1;
    localparam int CNT_W = $clog2(MAX_RECO_JETS + 1);

    localparam int ANGLE_W = 15;
    localparam int PT_W    = 16;
    localparam int DE_W    = 15;
    localparam int DP_W    = 14;
    localparam int DIST_W  = 32;
    localparam int INDEX_W = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W = 2 * ANGLE_W + PT_W;

    localparam logic [ANGLE_W-1:0] PI_FX     = 15'd12868;
    localparam logic [ANGLE_W-1:0] TWO_PI_FX = 15'd25736;

    localparam logic [DIST_W-1:0] CONE_RESET   = 32'd2683044;
    localparam logic [PT_W-1:0]   PT_MIN_RESET = 16'd640;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CONE   = 2'd0,
        CFG_PT_MIN = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start_event;
        logic load_jet;
        logic load_query;
        logic issue;
        logic ld_result;
    } t_dp_cmd;

    typedef struct packed {
        logic query_short;
        logic scan_last;
        logic pipe_empty;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/drjm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drjm_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module drjm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/drjm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drjm_ctrl
// sequencer: takes transactions, walks the reco table, hands off the result
// ----------------------------------------------------------------------------
module drjm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [drjm_pkg::KIND_W-1:0] i_kind,
    input  drjm_pkg::t_dp_status       i_status,
    output logic                       o_in_ready,
    output drjm_pkg::t_dp_cmd          o_cmd
);

    drjm_pkg::t_state r_state;
    drjm_pkg::t_state n_state;
    logic             s_accept;

    assign s_accept = i_in_valid && (r_state == drjm_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drjm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drjm_pkg::ST_IDLE: begin
                if (s_accept && (i_kind == drjm_pkg::KIND_QUERY)) begin
                    n_state = i_status.query_short ? drjm_pkg::ST_FINISH : drjm_pkg::ST_SCAN;
                end
            end
            drjm_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = drjm_pkg::ST_DRAIN;
                end
            end
            drjm_pkg::ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = drjm_pkg::ST_FINISH;
                end
            end
            drjm_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = drjm_pkg::ST_IDLE;
                end
            end
            default: n_state = drjm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == drjm_pkg::ST_IDLE);
        o_cmd.start_event = 1'b0;
        o_cmd.load_jet    = 1'b0;
        o_cmd.load_query  = 1'b0;
        o_cmd.issue       = (r_state == drjm_pkg::ST_SCAN);
        o_cmd.ld_result   = (r_state == drjm_pkg::ST_FINISH) && i_status.out_free;
        if (s_accept) begin
            unique case (drjm_pkg::t_kind'(i_kind))
                drjm_pkg::KIND_START: o_cmd.start_event = 1'b1;
                drjm_pkg::KIND_LOAD:  o_cmd.load_jet    = 1'b1;
                drjm_pkg::KIND_QUERY: o_cmd.load_query  = 1'b1;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/drjm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drjm_datapath
// reco table, distance pipeline, best-match tracking and result register
// ----------------------------------------------------------------------------
module drjm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  drjm_pkg::t_dp_cmd                 i_cmd,
    output drjm_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_we,
    input  logic [drjm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [drjm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic signed [drjm_pkg::ANGLE_W-1:0] i_jet_eta,
    input  logic signed [drjm_pkg::ANGLE_W-1:0] i_jet_phi,
    input  logic [drjm_pkg::PT_W-1:0]         i_jet_pt,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_matched,
    output logic                              o_skipped,
    output logic [drjm_pkg::INDEX_W-1:0]      o_match_index,
    output logic [drjm_pkg::PT_W-1:0]         o_match_pt,
    output logic [drjm_pkg::DIST_W-1:0]       o_match_distance_squared
);

    localparam int AW = drjm_pkg::ANGLE_W;

    // configuration
    logic [drjm_pkg::DIST_W-1:0] r_cone;
    logic [drjm_pkg::PT_W-1:0]   r_pt_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cone   <= drjm_pkg::CONE_RESET;
            r_pt_min <= drjm_pkg::PT_MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                drjm_pkg::CFG_CONE:   r_cone   <= i_cfg_data;
                drjm_pkg::CFG_PT_MIN: r_pt_min <= i_cfg_data[drjm_pkg::PT_W-1:0];
                default: ;
            endcase
        end
    end

    // reco table
    logic [drjm_pkg::CNT_W-1:0]   r_count;
    logic [drjm_pkg::IDX_W-1:0]   r_addr;
    logic                         s_table_we;
    logic [drjm_pkg::ENTRY_W-1:0] s_rdata;

    assign s_table_we = i_cmd.load_jet && (r_count < drjm_pkg::CNT_W'(drjm_pkg::MAX_RECO_JETS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.start_event) begin
            r_count <= '0;
        end else if (s_table_we) begin
            r_count <= r_count + drjm_pkg::CNT_W'(1);
        end
    end

    drjm_ram #(
        .WIDTH (drjm_pkg::ENTRY_W),
        .DEPTH (drjm_pkg::MAX_RECO_JETS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s_table_we),
        .i_waddr (r_count[drjm_pkg::IDX_W-1:0]),
        .i_wdata ({i_jet_eta, i_jet_phi, i_jet_pt}),
        .i_raddr (r_addr),
        .o_rdata (s_rdata)
    );

    // query
    logic [AW-1:0] r_q_eta;
    logic [AW-1:0] r_q_phi;
    logic          r_skip;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_q_eta <= i_jet_eta;
            r_q_phi <= i_jet_phi;
            r_skip  <= (i_jet_pt < r_pt_min);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load_query) begin
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + drjm_pkg::IDX_W'(1);
        end
    end

    // stage 1: table read in flight
    logic                       r_v1;
    logic [drjm_pkg::IDX_W-1:0] r_idx1;
    // stage 2: differences
    logic                       r_v2;
    logic [drjm_pkg::IDX_W-1:0] r_idx2;
    logic [drjm_pkg::DE_W-1:0]  r_de;
    logic [drjm_pkg::DP_W-1:0]  r_dp;
    logic [drjm_pkg::PT_W-1:0]  r_pt2;
    // stage 3: squared distance
    logic                       r_v3;
    logic [drjm_pkg::IDX_W-1:0] r_idx3;
    logic [drjm_pkg::DIST_W-1:0] r_d2;
    logic [drjm_pkg::PT_W-1:0]  r_pt3;

    logic [AW-1:0]   s_rd_eta;
    logic [AW-1:0]   s_rd_phi;
    logic [AW:0]     s_deta;
    logic [AW:0]     s_dphi;
    logic [AW-1:0]   s_ade;
    logic [AW-1:0]   s_adp;
    logic [AW-1:0]   s_fold;
    logic [2*drjm_pkg::DE_W-1:0] s_de_sq;
    logic [2*drjm_pkg::DP_W-1:0] s_dp_sq;

    assign s_rd_eta = s_rdata[drjm_pkg::ENTRY_W-1 -: AW];
    assign s_rd_phi = s_rdata[drjm_pkg::PT_W +: AW];
    assign s_deta   = {s_rd_eta[AW-1], s_rd_eta} - {r_q_eta[AW-1], r_q_eta};
    assign s_dphi   = {s_rd_phi[AW-1], s_rd_phi} - {r_q_phi[AW-1], r_q_phi};
    // magnitudes never exceed 2^15 - 1, so the top bit drops
    assign s_ade    = s_deta[AW] ? AW'(-s_deta) : s_deta[AW-1:0];
    assign s_adp    = s_dphi[AW] ? AW'(-s_dphi) : s_dphi[AW-1:0];

    // fold |dphi| into 0..pi, taking the magnitude past 2*pi
    always_comb begin
        if (s_adp <= drjm_pkg::PI_FX) begin
            s_fold = s_adp;
        end else if (s_adp <= drjm_pkg::TWO_PI_FX) begin
            s_fold = drjm_pkg::TWO_PI_FX - s_adp;
        end else begin
            s_fold = s_adp - drjm_pkg::TWO_PI_FX;
        end
    end

    assign s_de_sq = r_de * r_de;
    assign s_dp_sq = r_dp * r_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_addr;
        r_idx2 <= r_idx1;
        r_de   <= s_ade[drjm_pkg::DE_W-1:0];
        r_dp   <= s_fold[drjm_pkg::DP_W-1:0];
        r_pt2  <= s_rdata[drjm_pkg::PT_W-1:0];
        r_idx3 <= r_idx2;
        r_d2   <= drjm_pkg::DIST_W'(s_de_sq) + drjm_pkg::DIST_W'(s_dp_sq);
        r_pt3  <= r_pt2;
    end

    // stage 4: nearest jet so far, lower index kept on a tie
    logic                        r_found;
    logic [drjm_pkg::DIST_W-1:0] r_best_d;
    logic [drjm_pkg::IDX_W-1:0]  r_best_idx;
    logic [drjm_pkg::PT_W-1:0]   r_best_pt;
    logic                        s_take;

    assign s_take = r_v3 && (r_d2 <= r_cone) && (!r_found || (r_d2 < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load_query) begin
            r_found <= 1'b0;
        end else if (s_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_best_d   <= r_d2;
            r_best_idx <= r_idx3;
            r_best_pt  <= r_pt3;
        end
    end

    // result register
    logic                         r_out_valid;
    logic                         r_matched;
    logic                         r_skipped;
    logic [drjm_pkg::INDEX_W-1:0] r_index;
    logic [drjm_pkg::PT_W-1:0]    r_pt;
    logic [drjm_pkg::DIST_W-1:0]  r_dist;
    logic                         s_hit;

    assign s_hit = r_found && !r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_result) begin
            r_matched <= s_hit;
            r_skipped <= r_skip;
            r_index   <= s_hit ? drjm_pkg::INDEX_W'(r_best_idx) : '0;
            r_pt      <= s_hit ? r_best_pt : '0;
            r_dist    <= s_hit ? r_best_d : '0;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_matched                = r_matched;
    assign o_skipped                = r_skipped;
    assign o_match_index            = r_index;
    assign o_match_pt               = r_pt;
    assign o_match_distance_squared = r_dist;

    assign o_status.query_short = (i_jet_pt < r_pt_min) || (r_count == '0);
    assign o_status.scan_last   = (drjm_pkg::CNT_W'(r_addr) == (r_count - drjm_pkg::CNT_W'(1)));
    assign o_status.pipe_empty  = !r_v1 && !r_v2 && !r_v3;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

endmodule

@@ rtl/delta_r_jet_matcher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_r_jet_matcher_top
// nearest reco jet matching of truth jets in eta-phi space
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) carries kind, eta, phi and pt.
// a start transaction clears the reco table, a load transaction appends one
// reco jet (dropped once the table holds 16). a truth query below
// truth_pt_min, or one against an empty table, skips the table walk and goes
// straight to its last step. otherwise the query streams the stored jets
// through a four-stage distance pipeline, one jet per cycle, and the result
// register loads once the pipeline has drained. the next transaction is taken
// once the result is in the output register (o_out_valid / i_out_ready), so a
// new query overlaps with an untaken result. if the receiver stalls, a
// finished query waits in its last step until the output register frees up.
// config writes (i_cfg_we, i_cfg_addr, i_cfg_data) are applied at once and
// belong between transactions. synchronous reset empties the table, restores
// cone radius squared 2683044 and pt threshold 640, and drops any result.
// ----------------------------------------------------------------------------
`include "delta_r_jet_matcher_top_defines.svh"

module delta_r_jet_matcher_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [drjm_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [drjm_pkg::ANGLE_W-1:0] i_jet_eta,
    input  logic signed [drjm_pkg::ANGLE_W-1:0] i_jet_phi,
    input  logic [drjm_pkg::PT_W-1:0]           i_jet_pt,
    input  logic                                i_cfg_we,
    input  logic [drjm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [drjm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_matched,
    output logic                                o_skipped,
    output logic [drjm_pkg::INDEX_W-1:0]        o_match_index,
    output logic [drjm_pkg::PT_W-1:0]           o_match_pt,
    output logic [drjm_pkg::DIST_W-1:0]         o_match_distance_squared
);

    drjm_pkg::t_dp_cmd    s_cmd;
    drjm_pkg::t_dp_status s_status;

    drjm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (s_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (s_cmd)
    );

    drjm_datapath u_datapath (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (s_cmd),
        .o_status                 (s_status),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_addr               (i_cfg_addr),
        .i_cfg_data               (i_cfg_data),
        .i_jet_eta                (i_jet_eta),
        .i_jet_phi                (i_jet_phi),
        .i_jet_pt                 (i_jet_pt),
        .i_out_ready              (i_out_ready),
        .o_out_valid              (o_out_valid),
        .o_matched                (o_matched),
        .o_skipped                (o_skipped),
        .o_match_index            (o_match_index),
        .o_match_pt               (o_match_pt),
        .o_match_distance_squared (o_match_distance_squared)
    );

    // a skipped or unmatched result carries all-zero match fields
    `DRJM_ASSERT_NOW(a_nomatch_zero, i_clk, i_rst_n, o_out_valid && !o_matched, (o_match_index == '0) && (o_match_pt == '0) && (o_match_distance_squared == '0))
    `DRJM_ASSERT_NOW(a_skip_excl, i_clk, i_rst_n, o_out_valid && o_skipped, !o_matched)
    // the table walk never overlaps with taking a new transaction
    `DRJM_ASSERT_NOW(a_scan_busy, i_clk, i_rst_n, s_cmd.issue, !o_in_ready)
    // a result load always lands in a free output register
    `DRJM_ASSERT_NEXT(a_ld_result, i_clk, i_rst_n, s_cmd.ld_result, o_out_valid)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for delta_r_jet_matcher_top: builds reco jet events,
// fires truth queries at them and checks every result against an in-bench
// nearest-neighbor predictor, under random gaps on both handshakes
// ----------------------------------------------------------------------------
module tb;
    import drjm_pkg::*;

    localparam int ITEM_TARGET   = 1700;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 32;
    localparam int IDLE_PERCENT  = 28;
    localparam int PI_ANGLE      = PI_FX;
    localparam int TWO_PI_ANGLE  = TWO_PI_FX;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic               matched;
        logic               skipped;
        logic [INDEX_W-1:0] match_index;
        logic [PT_W-1:0]    match_pt;
        logic [DIST_W-1:0]  match_distance_squared;
    } t_match_result;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [KIND_W-1:0]           i_kind     = '0;
    logic signed [ANGLE_W-1:0]   i_jet_eta  = '0;
    logic signed [ANGLE_W-1:0]   i_jet_phi  = '0;
    logic [PT_W-1:0]             i_jet_pt   = '0;
    logic                        i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic                        o_matched;
    logic                        o_skipped;
    logic [INDEX_W-1:0]          o_match_index;
    logic [PT_W-1:0]             o_match_pt;
    logic [DIST_W-1:0]           o_match_distance_squared;

    // predictor copy of the jet table and the thresholds
    logic signed [ANGLE_W-1:0] jet_eta_store [MAX_RECO_JETS];
    logic signed [ANGLE_W-1:0] jet_phi_store [MAX_RECO_JETS];
    logic [PT_W-1:0]           jet_pt_store  [MAX_RECO_JETS];
    int                        stored_jets = 0;
    logic [DIST_W-1:0]         cone_sq_setting = CONE_RESET;
    logic [PT_W-1:0]           pt_cut_setting  = PT_MIN_RESET;

    t_match_result expected_matches[$];
    bit            no_idle = 1'b0;
    int            items_sent = 0;
    int            queries_sent = 0;
    int            matches_predicted = 0;
    int            skips_predicted = 0;
    int            results_checked = 0;
    int            mismatch_count = 0;
    int            cycles_run = 0;

    delta_r_jet_matcher_top dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_kind                   (i_kind),
        .i_jet_eta                (i_jet_eta),
        .i_jet_phi                (i_jet_phi),
        .i_jet_pt                 (i_jet_pt),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_addr               (i_cfg_addr),
        .i_cfg_data               (i_cfg_data),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_matched                (o_matched),
        .o_skipped                (o_skipped),
        .o_match_index            (o_match_index),
        .o_match_pt               (o_match_pt),
        .o_match_distance_squared (o_match_distance_squared)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // nearest stored jet inside the cone, lowest index on a tie
    function automatic t_match_result predict_match(logic signed [ANGLE_W-1:0] eta,
                                                    logic signed [ANGLE_W-1:0] phi,
                                                    logic [PT_W-1:0] pt);
        t_match_result res;
        int            d_eta;
        int            d_phi;
        longint        jet_dist;
        longint        best_dist;
        bit            found;
        res = '0;
        found = 1'b0;
        best_dist = 0;
        if (pt < pt_cut_setting) begin
            res.skipped = 1'b1;
            return res;
        end
        for (int i = 0; i < stored_jets; i++) begin
            d_eta = int'(jet_eta_store[i]) - int'(eta);
            if (d_eta < 0) d_eta = -d_eta;
            d_phi = int'(jet_phi_store[i]) - int'(phi);
            if (d_phi < 0) d_phi = -d_phi;
            // fold the azimuth gap back into 0..pi
            if (d_phi > PI_ANGLE) d_phi = TWO_PI_ANGLE - d_phi;
            if (d_phi < 0) d_phi = -d_phi;
            jet_dist = longint'(d_eta) * d_eta + longint'(d_phi) * d_phi;
            if (jet_dist <= longint'(cone_sq_setting) && (!found || jet_dist < best_dist)) begin
                found = 1'b1;
                best_dist = jet_dist;
                res.match_index = INDEX_W'(i);
                res.match_pt = jet_pt_store[i];
            end
        end
        if (found) begin
            res.matched = 1'b1;
            res.match_distance_squared = DIST_W'(best_dist);
        end
        return res;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] rand_eta();
        if ($urandom_range(3) == 0) return ANGLE_W'($urandom);
        return ANGLE_W'($urandom_range(16384) - 8192);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] rand_phi();
        if ($urandom_range(7) == 0) return ANGLE_W'($urandom);
        return ANGLE_W'($urandom_range(TWO_PI_ANGLE) - PI_ANGLE);
    endfunction

    function automatic logic [PT_W-1:0] rand_query_pt();
        case ($urandom_range(5))
            0: return (pt_cut_setting == 0) ? '0 : PT_W'($urandom_range(pt_cut_setting - 1));
            1: return pt_cut_setting;
            default: return PT_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                                      results_checked, name, got, want));
        end
    endtask

    // one input transaction, predictor updated at the accepting edge
    task automatic send_item(logic [KIND_W-1:0] kind, logic signed [ANGLE_W-1:0] eta,
                             logic signed [ANGLE_W-1:0] phi, logic [PT_W-1:0] pt);
        t_match_result want;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_jet_eta  <= eta;
        i_jet_phi  <= phi;
        i_jet_pt   <= pt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (kind)
            KIND_START: stored_jets = 0;
            KIND_LOAD: begin
                if (stored_jets < MAX_RECO_JETS) begin
                    jet_eta_store[stored_jets] = eta;
                    jet_phi_store[stored_jets] = phi;
                    jet_pt_store[stored_jets]  = pt;
                    stored_jets++;
                end
            end
            KIND_QUERY: begin
                want = predict_match(eta, phi, pt);
                expected_matches.insert(expected_matches.size(), want);
                queries_sent++;
                if (want.matched) matches_predicted++;
                if (want.skipped) skips_predicted++;
            end
            default: ;
        endcase
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        // start and load transactions leave no result to wait on
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_matcher(logic [DIST_W-1:0] cone, logic [PT_W-1:0] pt_cut);
        wait_until_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_CONE;
        i_cfg_data <= cone;
        @(posedge i_clk);
        i_cfg_addr <= CFG_PT_MIN;
        i_cfg_data <= CFG_DATA_W'(pt_cut);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cone_sq_setting = cone;
        pt_cut_setting  = pt_cut;
    endtask

    // mostly well-formed: start, loads, then queries aimed near stored jets
    task automatic run_event(int n_loads, int n_queries);
        logic signed [ANGLE_W-1:0] eta;
        logic signed [ANGLE_W-1:0] phi;
        int                        pick;
        if ($urandom_range(9) != 0) send_item(KIND_START, rand_eta(), rand_phi(), PT_W'($urandom));
        repeat (n_loads) begin
            if ($urandom_range(19) == 0) begin
                send_item(KIND_UNUSED, rand_eta(), rand_phi(), PT_W'($urandom));
            end
            if (stored_jets > 0 && stored_jets < MAX_RECO_JETS && $urandom_range(7) == 0) begin
                // same position as an earlier jet forces a distance tie
                pick = $urandom_range(stored_jets - 1);
                send_item(KIND_LOAD, jet_eta_store[pick], jet_phi_store[pick], PT_W'($urandom));
            end else begin
                send_item(KIND_LOAD, rand_eta(), rand_phi(), PT_W'($urandom));
            end
        end
        repeat (n_queries) begin
            if (stored_jets > 0 && $urandom_range(3) != 0) begin
                pick = $urandom_range(stored_jets - 1);
                eta = jet_eta_store[pick];
                phi = jet_phi_store[pick];
                if ($urandom_range(4) != 0) begin
                    eta = eta + ANGLE_W'($urandom_range(2400) - 1200);
                    phi = phi + ANGLE_W'($urandom_range(2400) - 1200);
                end
            end else begin
                eta = rand_eta();
                phi = rand_phi();
            end
            send_item(KIND_QUERY, eta, phi, rand_query_pt());
        end
    endtask

    task automatic test_reset_state();
        // empty table with the power-on thresholds
        send_item(KIND_QUERY, '0, '0, PT_MIN_RESET);
        send_item(KIND_QUERY, 15'sd100, -15'sd100, PT_MIN_RESET - 16'd1);
    endtask

    task automatic test_matching_corners();
        send_item(KIND_START, -15'sd1, -15'sd1, 16'hffff);
        send_item(KIND_LOAD, 15'sd0, 15'sd0, 16'hffff);
        send_item(KIND_LOAD, 15'sd0, 15'sd0, 16'd100);
        send_item(KIND_LOAD, 15'sd16383, 15'sd12868, 16'd0);
        send_item(KIND_LOAD, -15'sd16384, -15'sd12868, 16'd1);
        send_item(KIND_LOAD, 15'sd8192, 15'sd4096, 16'd7);
        send_item(KIND_UNUSED, -15'sd1, -15'sd1, 16'hffff);
        // two jets at the origin, the lower index must win
        send_item(KIND_QUERY, 15'sd0, 15'sd0, 16'hffff);
        // match across the +-pi seam
        send_item(KIND_QUERY, 15'sd16383, -15'sd12868, PT_MIN_RESET);
        // exactly on the cone edge
        send_item(KIND_QUERY, 15'sd9830, 15'sd4096, 16'd1000);
        // azimuth beyond pi on the query side
        send_item(KIND_QUERY, -15'sd16384, 15'sd16383, 16'd2000);
        send_item(KIND_QUERY, 15'sd0, 15'sd0, PT_MIN_RESET - 16'd1);
        send_item(KIND_QUERY, 15'sd0, 15'sd0, 16'd0);
    endtask

    task automatic test_table_overflow();
        for (int k = 5; k < MAX_RECO_JETS; k++) begin
            send_item(KIND_LOAD, ANGLE_W'(k * 1500 - 12000), ANGLE_W'(k * 700 - 6000),
                      PT_W'(k * 100));
        end
        // table is full, this jet must never be seen
        send_item(KIND_LOAD, -15'sd4096, -15'sd4096, 16'd4242);
        send_item(KIND_QUERY, -15'sd4096, -15'sd4096, 16'd5000);
        send_item(KIND_QUERY, 15'sd10500, 15'sd4500, 16'd5000);
    endtask

    task automatic test_threshold_extremes();
        program_matcher('0, '0);
        repeat (4) run_event($urandom_range(1, 16), $urandom_range(2, 5));
        program_matcher('1, '1);
        repeat (2) run_event($urandom_range(1, 16), $urandom_range(2, 5));
        program_matcher('1, '0);
        repeat (4) run_event($urandom_range(1, 16), $urandom_range(2, 5));
        program_matcher(CONE_RESET, PT_MIN_RESET);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (12) run_event($urandom_range(4, 16), $urandom_range(2, 6));
        no_idle = 1'b0;
    endtask

    task automatic test_random_events();
        logic [DIST_W-1:0] cone;
        logic [PT_W-1:0]   pt_cut;
        int                events_done;
        events_done = 0;
        while (items_sent < ITEM_TARGET) begin
            if (events_done % 12 == 0) begin
                case ($urandom_range(5))
                    0: cone = '0;
                    1: cone = '1;
                    2: cone = CONE_RESET;
                    3: cone = $urandom_range(32'd12000000);
                    4: cone = $urandom_range(32'd4194304);
                    default: cone = $urandom;
                endcase
                case ($urandom_range(7))
                    0: pt_cut = '0;
                    1: pt_cut = '1;
                    2: pt_cut = PT_MIN_RESET;
                    3: pt_cut = PT_W'($urandom);
                    default: pt_cut = PT_W'($urandom_range(4000));
                endcase
                program_matcher(cone, pt_cut);
            end
            run_event($urandom_range(20), $urandom_range(1, 6));
            events_done++;
        end
    endtask

    // result checker, also drives the receiver stalls
    always @(posedge i_clk) begin : check_results
        t_match_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no query pending",
                                          results_checked));
            end else begin
                want = expected_matches.pop_front();
                compare_field("matched", DIST_W'(o_matched), DIST_W'(want.matched));
                compare_field("skipped", DIST_W'(o_skipped), DIST_W'(want.skipped));
                compare_field("match_index", DIST_W'(o_match_index), DIST_W'(want.match_index));
                compare_field("match_pt", DIST_W'(o_match_pt), DIST_W'(want.match_pt));
                compare_field("match_distance_squared", o_match_distance_squared,
                              want.match_distance_squared);
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial begin
        for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge i_clk);
        $display("timeout with %0d results outstanding", expected_matches.size());
        $display("delta_r_jet_matcher_top test failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_matching_corners();
        test_table_overflow();
        test_threshold_extremes();
        test_back_to_back();
        test_random_events();
        wait_until_idle();
        $display("covered %0d transactions, %0d truth queries (%0d matched, %0d skipped)",
                 items_sent, queries_sent, matches_predicted, skips_predicted);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 results_checked, cycles_run, mismatch_count);
        if (mismatch_count == 0 && expected_matches.size() == 0) begin
            $display("delta_r_jet_matcher_top test passed");
        end else begin
            $display("delta_r_jet_matcher_top test failed");
        end
        $finish;
    end

endmodule
